[hw/rtl/pyramid_lod_visible_tile_range_assert.svh]
// assertion macros for the pyramid tile range block
`ifndef PYRAMID_LOD_VISIBLE_TILE_RANGE_ASSERT_SVH
`define PYRAMID_LOD_VISIBLE_TILE_RANGE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define PLVTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define PLVTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/plvtr_pkg.sv]
// ----------------------------------------------------------------------------
// plvtr_pkg
// Types and constants of the pyramid level / visible tile range block.
// ----------------------------------------------------------------------------
`default_nettype none

package plvtr_pkg;

    localparam int TILE_EDGE_DEF  = 256;
    localparam int MAX_LEVELS_DEF = 16;

    localparam int DIVN_W = 62;
    localparam int DIVS_W = 54;
    localparam int REM_W  = 55;
    localparam int DCNT_W = 6;
    localparam int MULA_W = 32;
    localparam int MULB_W = 24;
    localparam int PROD_W = 56;
    localparam int EXT_W  = 41;
    localparam int APROD_W = 48;
    localparam int TQ_W   = 28;
    localparam int MT_W   = 13;

    localparam logic [1:0] CFG_IMG_W  = 2'd0;
    localparam logic [1:0] CFG_IMG_H  = 2'd1;
    localparam logic [1:0] CFG_VIEW_W = 2'd2;
    localparam logic [1:0] CFG_VIEW_H = 2'd3;

    typedef struct packed {
        logic [23:0]        zoom;
        logic signed [19:0] pan_x;
        logic signed [19:0] pan_y;
    } t_req;

    typedef struct packed {
        logic [3:0] lod;
        logic [7:0] first_col;
        logic [7:0] last_col;
        logic [7:0] first_row;
        logic [7:0] last_row;
        logic       empty_res;
    } t_res;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CMP1,
        ST_CMP2,
        ST_NW,
        ST_NH,
        ST_DZ,
        ST_DW,
        ST_DH,
        ST_DVW,
        ST_DVH,
        ST_EW,
        ST_EH,
        ST_DEX,
        ST_DEY,
        ST_SEARCH,
        ST_LO,
        ST_LODIV,
        ST_HI,
        ST_HIDIV,
        ST_MT,
        ST_CNT,
        ST_AXFIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/pyramid_lod_visible_tile_range.sv]
// ----------------------------------------------------------------------------
// pyramid_lod_visible_tile_range
// Picks the pyramid level for a view and returns its visible tile rectangle.
// ----------------------------------------------------------------------------
// Usage:
//  - configuration through the APB-style port: image width/height at 0x0/0x4,
//    view width/height at 0x8/0xC; pready is always high, reads return values
//  - a request (zoom, pan_x, pan_y) is taken when start is high and busy low
//  - busy stays high for the whole transaction; one result follows on o_res,
//    marked by o_valid for exactly one cycle, in which busy is already low
//  - a request with a zero size or zero zoom goes straight to an empty result
//  - one shared restoring divider, one quotient bit a cycle, does four 62-bit
//    divides for display size and view extent; the level search checks one
//    level a cycle; tile bounds are shifts, so TILE_EDGE must be a power of
//    two, which the block does not check; one 32x24 multiplier serves all
//    products
//  - a new request can be taken in the o_valid cycle
//  - the level table follows the image size registers directly
//  - reset returns to idle with 256x256 image and 1024x1024 view
//  - the receiver cannot stall: a result not taken in its cycle is gone
// ----------------------------------------------------------------------------
`default_nettype none

module pyramid_lod_visible_tile_range #(
    parameter int TILE_EDGE  = plvtr_pkg::TILE_EDGE_DEF,
    parameter int MAX_LEVELS = plvtr_pkg::MAX_LEVELS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    input  wire logic            start,
    input  wire plvtr_pkg::t_req i_req,
    output logic                 busy,
    output logic                 o_valid,
    output plvtr_pkg::t_res      o_res
);
    import plvtr_pkg::*;

    localparam int                  TILE_SH   = $clog2(TILE_EDGE);
    localparam int                  TQ_SH     = TILE_SH + 17;
    localparam logic [APROD_W-1:0]  TILE_MASK = (APROD_W'(1) << TQ_SH) - APROD_W'(1);
    localparam logic [16:0]       TILE_M1  = 17'(TILE_EDGE - 1);
    localparam logic [DIVN_W-1:0] EXT_LIM  = DIVN_W'(1) << 40;
    localparam logic [31:0]       A_LIM    = 32'h8000_0000;

    // configuration
    logic [15:0] r_iw, r_ih;
    logic [13:0] r_vw, r_vh;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw <= 16'd256;
            r_ih <= 16'd256;
            r_vw <= 14'd1024;
            r_vh <= 14'd1024;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_IMG_W:  r_iw <= pwdata[15:0];
                CFG_IMG_H:  r_ih <= pwdata[15:0];
                CFG_VIEW_W: r_vw <= pwdata[13:0];
                CFG_VIEW_H: r_vh <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_IMG_W:  prdata = {16'd0, r_iw};
            CFG_IMG_H:  prdata = {16'd0, r_ih};
            CFG_VIEW_W: prdata = {18'd0, r_vw};
            CFG_VIEW_H: prdata = {18'd0, r_vh};
            default:    prdata = 32'd0;
        endcase
    end

    // level count from the image size
    logic [MAX_LEVELS-1:0] lv_ok;
    logic [4:0]            lv_total;

    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            lv_ok[i] = ((r_iw >> i) >= 16'(TILE_EDGE)) && ((r_ih >> i) >= 16'(TILE_EDGE));
        end
        lv_total = 5'($countones(lv_ok));
        if (lv_total == 5'd0) begin
            lv_total = 5'd1;
        end
    end

    // shared divider
    logic [DIVN_W-1:0] r_dvd, r_quo;
    logic [DIVS_W-1:0] r_dvs;
    logic [REM_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_dact;
    logic              div_load, div_clr, div_done;
    logic [DIVN_W-1:0] div_num;
    logic [DIVS_W-1:0] div_den;
    logic [DCNT_W-1:0] div_bits;
    logic [REM_W-1:0]  rem_sh;

    assign div_done = r_dact && (r_dcnt == '0);
    assign rem_sh   = {r_rem[REM_W-2:0], r_dvd[DIVN_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_dact <= 1'b0;
        end else if (div_load) begin
            r_dcnt <= div_bits;
            r_dact <= 1'b1;
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end else if (div_clr) begin
            r_dact <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_dvd <= div_num << (DCNT_W'(DIVN_W) - div_bits);
            r_dvs <= div_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_dcnt != '0) begin
            r_dvd <= r_dvd << 1;
            if (rem_sh >= {1'b0, r_dvs}) begin
                r_rem <= rem_sh - {1'b0, r_dvs};
                r_quo <= {r_quo[DIVN_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[DIVN_W-2:0], 1'b0};
            end
        end
    end

    // shared multiplier
    logic [MULA_W-1:0] mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // sequencer registers
    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_res   r_res, n_res;
    logic   r_valid, n_valid;
    logic [29:0] r_p1, n_p1, r_t0, n_t0, r_t1, n_t1, r_t2, n_t2, r_t3, n_t3;
    logic [13:0] r_num, n_num;
    logic [15:0] r_den, n_den;
    logic [39:0] r_dz, n_dz;
    logic [53:0] r_ew, n_ew, r_eh, n_eh;
    logic [DIVN_W-1:0] r_dispw, n_dispw, r_disph, n_disph;
    logic [EXT_W-1:0]  r_ex, n_ex, r_ey, n_ey;
    logic [62:0] r_best, n_best;
    logic [3:0]  r_idx, n_idx, r_lod, n_lod;
    logic        r_axis, n_axis, r_aneg, n_aneg, r_hneg, n_hneg;
    logic [APROD_W-1:0] r_prod, n_prod;
    logic [TQ_W-1:0]    r_s, n_s, r_e, n_e;
    logic [MT_W-1:0]    r_mt, n_mt, r_cntl, n_cntl;
    logic [7:0]  r_fx, n_fx, r_lx, n_lx;
    logic        r_okx, n_okx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_res   <= n_res;
        r_p1    <= n_p1;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_t3    <= n_t3;
        r_num   <= n_num;
        r_den   <= n_den;
        r_dz    <= n_dz;
        r_ew    <= n_ew;
        r_eh    <= n_eh;
        r_dispw <= n_dispw;
        r_disph <= n_disph;
        r_ex    <= n_ex;
        r_ey    <= n_ey;
        r_best  <= n_best;
        r_idx   <= n_idx;
        r_lod   <= n_lod;
        r_axis  <= n_axis;
        r_aneg  <= n_aneg;
        r_hneg  <= n_hneg;
        r_prod  <= n_prod;
        r_s     <= n_s;
        r_e     <= n_e;
        r_mt    <= n_mt;
        r_cntl  <= n_cntl;
        r_fx    <= n_fx;
        r_lx    <= n_lx;
        r_okx   <= n_okx;
    end

    function automatic logic [DIVN_W-1:0] absd(input logic [DIVN_W-1:0] a,
                                               input logic [DIVN_W-1:0] b);
        absd = (a > b) ? (a - b) : (b - a);
    endfunction

    // level search distance
    logic [15:0] sw_lw, sw_lh;
    logic [62:0] sw_d;

    assign sw_lw = r_iw >> r_idx;
    assign sw_lh = r_ih >> r_idx;
    assign sw_d  = {1'b0, absd(DIVN_W'({sw_lw, 16'd0}), r_dispw)}
                 + {1'b0, absd(DIVN_W'({sw_lh, 16'd0}), r_disph)};

    // per-axis corner position, clamped
    logic signed [19:0] ax_pan;
    logic [EXT_W-1:0]   ax_ext;
    logic [15:0]        ax_img, ax_lvl;
    logic [42:0]        ax_a, ax_neg;
    logic [31:0]        ax_mag;

    assign ax_pan = r_axis ? r_req.pan_y : r_req.pan_x;
    assign ax_ext = r_axis ? r_ey : r_ex;
    assign ax_img = r_axis ? r_ih : r_iw;
    assign ax_lvl = ax_img >> r_lod;

    always_comb begin
        if (r_state == ST_HI) begin
            ax_a = {{23{ax_pan[19]}}, ax_pan} + {2'd0, ax_ext} + 43'd65536;
        end else begin
            ax_a = {{23{ax_pan[19]}}, ax_pan} - {2'd0, ax_ext} + 43'd65536;
        end
        ax_neg = ax_a[42] ? (43'd0 - ax_a) : ax_a;
        ax_mag = (ax_neg > 43'(A_LIM)) ? A_LIM : ax_neg[31:0];
    end

    // per-axis final range
    logic [MT_W-1:0] fn_epos, fn_cm1;
    logic [16:0]     fn_sm1, fn_ep, fn_ecl;
    logic [TQ_W-1:0] fn_ssh;
    logic            fn_eneg, fn_ok;
    logic [7:0]      fn_first, fn_last;

    always_comb begin
        fn_epos = (r_e > TQ_W'(r_mt)) ? r_mt : r_e[MT_W-1:0];
        fn_sm1  = (17'd1 << r_lod) - 17'd1;
        fn_ep   = (17'(fn_epos) + fn_sm1) >> r_lod;
        fn_cm1  = r_cntl - 1'b1;
        if (r_hneg) begin
            fn_ecl = 17'd0;
        end else begin
            fn_ecl = (fn_ep > 17'(fn_cm1)) ? 17'(fn_cm1) : fn_ep;
        end
        fn_eneg  = r_hneg && ((r_e >> r_lod) != '0);
        fn_ssh   = r_s >> r_lod;
        fn_ok    = !fn_eneg && (fn_ssh <= TQ_W'(fn_ecl)) && (fn_ssh < TQ_W'(r_cntl));
        fn_first = (fn_ssh > TQ_W'(255)) ? 8'd255 : fn_ssh[7:0];
        fn_last  = (fn_ecl > 17'd255) ? 8'd255 : fn_ecl[7:0];
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_req   = r_req;
        n_res   = r_res;
        n_p1    = r_p1;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_t2    = r_t2;
        n_t3    = r_t3;
        n_num   = r_num;
        n_den   = r_den;
        n_dz    = r_dz;
        n_ew    = r_ew;
        n_eh    = r_eh;
        n_dispw = r_dispw;
        n_disph = r_disph;
        n_ex    = r_ex;
        n_ey    = r_ey;
        n_best  = r_best;
        n_idx   = r_idx;
        n_lod   = r_lod;
        n_axis  = r_axis;
        n_aneg  = r_aneg;
        n_hneg  = r_hneg;
        n_prod  = r_prod;
        n_s     = r_s;
        n_e     = r_e;
        n_mt    = r_mt;
        n_cntl  = r_cntl;
        n_fx    = r_fx;
        n_lx    = r_lx;
        n_okx   = r_okx;
        mul_a   = '0;
        mul_b   = '0;
        div_load = 1'b0;
        div_clr  = 1'b0;
        div_num  = '0;
        div_den  = '0;
        div_bits = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    if (r_iw == '0 || r_ih == '0 || r_vw == '0 || r_vh == '0 ||
                        i_req.zoom == '0) begin
                        n_res = '0;
                        n_res.empty_res = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CMP1;
                    end
                end
            end
            ST_CMP1: begin
                mul_a = 32'(r_vw);
                mul_b = 24'(r_ih);
                n_p1 = mul_p[29:0];
                n_state = ST_CMP2;
            end
            ST_CMP2: begin
                mul_a = 32'(r_vh);
                mul_b = 24'(r_iw);
                if (r_p1 <= mul_p[29:0]) begin
                    n_num = r_vw;
                    n_den = r_iw;
                end else begin
                    n_num = r_vh;
                    n_den = r_ih;
                end
                n_state = ST_NW;
            end
            ST_NW: begin
                mul_a = 32'(r_iw);
                mul_b = 24'(r_num);
                n_t0 = mul_p[29:0];
                n_state = ST_NH;
            end
            ST_NH: begin
                mul_a = 32'(r_ih);
                mul_b = 24'(r_num);
                n_t1 = mul_p[29:0];
                n_state = ST_DZ;
            end
            ST_DZ: begin
                mul_a = 32'(r_den);
                mul_b = r_req.zoom;
                n_dz = mul_p[39:0];
                n_state = ST_DW;
            end
            ST_DW, ST_DH: begin
                div_num  = {(r_state == ST_DW) ? r_t0 : r_t1, 32'd0};
                div_den  = DIVS_W'(r_dz);
                div_bits = DCNT_W'(DIVN_W);
                if (!r_dact) begin
                    div_load = 1'b1;
                end else if (div_done) begin
                    div_clr = 1'b1;
                    if (r_state == ST_DW) begin
                        n_dispw = r_quo;
                        n_state = ST_DH;
                    end else begin
                        n_disph = r_quo;
                        n_state = ST_DVW;
                    end
                end
            end
            ST_DVW: begin
                mul_a = 32'(r_den);
                mul_b = 24'(r_vw);
                n_t2 = mul_p[29:0];
                n_state = ST_DVH;
            end
            ST_DVH: begin
                mul_a = 32'(r_den);
                mul_b = 24'(r_vh);
                n_t3 = mul_p[29:0];
                n_state = ST_EW;
            end
            ST_EW: begin
                mul_a = 32'(r_t0);
                mul_b = r_req.zoom;
                n_ew = mul_p[53:0];
                n_state = ST_EH;
            end
            ST_EH: begin
                mul_a = 32'(r_t1);
                mul_b = r_req.zoom;
                n_eh = mul_p[53:0];
                n_state = ST_DEX;
            end
            ST_DEX, ST_DEY: begin
                div_num  = {(r_state == ST_DEX) ? r_t2 : r_t3, 32'd0};
                div_den  = (r_state == ST_DEX) ? r_ew : r_eh;
                div_bits = DCNT_W'(DIVN_W);
                if (!r_dact) begin
                    div_load = 1'b1;
                end else if (div_done) begin
                    div_clr = 1'b1;
                    if (r_state == ST_DEX) begin
                        n_ex = (r_quo > EXT_LIM) ? EXT_W'(EXT_LIM) : r_quo[EXT_W-1:0];
                        n_state = ST_DEY;
                    end else begin
                        n_ey = (r_quo > EXT_LIM) ? EXT_W'(EXT_LIM) : r_quo[EXT_W-1:0];
                        n_idx  = '0;
                        n_lod  = '0;
                        n_best = '1;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (sw_d < r_best) begin
                    n_best = sw_d;
                    n_lod  = r_idx;
                end
                if (5'(r_idx) == lv_total - 5'd1) begin
                    n_axis  = 1'b0;
                    n_state = ST_LO;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LO, ST_HI: begin
                mul_a  = ax_mag;
                mul_b  = 24'(ax_img);
                n_prod = mul_p[APROD_W-1:0];
                n_aneg = ax_a[42];
                n_state = (r_state == ST_LO) ? ST_LODIV : ST_HIDIV;
            end
            ST_LODIV, ST_HIDIV: begin
                if (r_state == ST_LODIV) begin
                    n_s = r_aneg ? '0 : TQ_W'(r_prod >> TQ_SH);
                    n_state = ST_HI;
                end else begin
                    n_hneg = r_aneg;
                    n_e = TQ_W'(r_prod >> TQ_SH) +
                          TQ_W'(!r_aneg && ((r_prod & TILE_MASK) != '0));
                    n_state = ST_MT;
                end
            end
            ST_MT, ST_CNT: begin
                if (r_state == ST_MT) begin
                    n_mt = MT_W'((17'(ax_img) + TILE_M1) >> TILE_SH);
                    n_state = ST_CNT;
                end else begin
                    n_cntl = MT_W'((17'(ax_lvl) + TILE_M1) >> TILE_SH);
                    n_state = ST_AXFIN;
                end
            end
            ST_AXFIN: begin
                if (!r_axis) begin
                    n_fx   = fn_first;
                    n_lx   = fn_last;
                    n_okx  = fn_ok;
                    n_axis = 1'b1;
                    n_state = ST_LO;
                end else begin
                    n_res = '0;
                    n_res.lod = r_lod;
                    if (r_okx && fn_ok) begin
                        n_res.first_col = r_fx;
                        n_res.last_col  = r_lx;
                        n_res.first_row = fn_first;
                        n_res.last_row  = fn_last;
                    end else begin
                        n_res.empty_res = 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`include "pyramid_lod_visible_tile_range_assert.svh"

    `PLVTR_ASSERT_NXT(a_strobe_one, o_valid, !o_valid, "result strobe longer than one cycle")
    `PLVTR_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
    `PLVTR_ASSERT_IMP(a_valid_idle, o_valid, !busy, "result strobe while still working")
    `PLVTR_ASSERT_IMP(a_empty_zero, o_valid && o_res.empty_res,
        o_res.first_col == 8'd0 && o_res.last_col == 8'd0 &&
        o_res.first_row == 8'd0 && o_res.last_row == 8'd0, "empty result has nonzero range")
    `PLVTR_ASSERT_IMP(a_div_owned, r_dact,
        r_state == ST_DW || r_state == ST_DH || r_state == ST_DEX || r_state == ST_DEY,
        "divider active outside a divide step")

endmodule

`default_nettype wire
